[hw/rtl/pcg_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package pcg_pkg;

    localparam int unsigned DATA_W     = 32;
    localparam int unsigned OP_W       = 2;
    localparam int unsigned LEN_W      = 7;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned IN_DATA_W  = 72;
    localparam int unsigned OUT_DATA_W = 112;
    localparam int unsigned OUT_PAD_W  = 7;

    // fnv-1a 32-bit offset basis and prime
    localparam logic [DATA_W-1:0] FNV_BASIS = 32'h811C_9DC5;
    localparam logic [DATA_W-1:0] FNV_PRIME = 32'h0100_0193;
    localparam logic [LEN_W-1:0]  LEN_MAX   = 7'd127;

    localparam logic [DATA_W-1:0] MAX_RUN_RST  = 32'd30000;
    localparam logic [DATA_W-1:0] COOLDOWN_RST = 32'd300000;
    localparam logic [DATA_W-1:0] HOST_TO_RST  = 32'd10000;

    typedef enum logic [OP_W-1:0] {
        OP_ID_BYTE = 2'd0,
        OP_REQUEST = 2'd1,
        OP_TICK    = 2'd2,
        OP_HOST    = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        REJ_NONE     = 3'd0,
        REJ_BAD      = 3'd1,
        REJ_DUP      = 3'd2,
        REJ_BUSY     = 3'd3,
        REJ_COOLDOWN = 3'd4
    } t_reject;

    typedef enum logic [1:0] {
        CAUSE_NONE     = 2'd0,
        CAUSE_VOLUME   = 2'd1,
        CAUSE_MAX_RUN  = 2'd2,
        CAUSE_WATCHDOG = 2'd3
    } t_cause;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAX_RUN      = 2'd0,
        CFG_COOLDOWN     = 2'd1,
        CFG_HOST_TIMEOUT = 2'd2
    } t_cfg_idx;

    // input beat, last field in the lowest bits
    typedef struct packed {
        logic [DATA_W-1:0] now_ms;
        logic [DATA_W-1:0] requested_ms;
        logic [7:0]        id_byte;
    } t_in_beat;

    // result beat, last field in the lowest bits
    typedef struct packed {
        logic [OUT_PAD_W-1:0] pad;
        logic                 pump_on;
        logic [DATA_W-1:0]    lockout_left_ms;
        logic [DATA_W-1:0]    run_time_ms;
        logic [1:0]           stop_cause;
        logic                 stopped;
        logic                 was_clamped;
        logic [DATA_W-1:0]    granted_ms;
        logic [2:0]           reject_reason;
        logic                 accepted;
    } t_out_beat;

    typedef struct packed {
        logic start;
        logic scan;
        logic exec;
        logic lk1;
        logic lk2;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic op_req;
        logic scan_done;
    } t_dp_status;

endpackage

`default_nettype wire

[hw/rtl/pcg_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none

module pcg_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_valid,
    input  logic                i_m_ready,
    input  pcg_pkg::t_dp_status i_status,
    output pcg_pkg::t_dp_cmd    o_cmd,
    output logic                o_s_ready,
    output logic                o_m_valid
);
    import pcg_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_SCAN = 6'b000010,
        ST_EXEC = 6'b000100,
        ST_LK1  = 6'b001000,
        ST_LK2  = 6'b010000,
        ST_FIN  = 6'b100000
    } t_state;

    t_state  r_state;
    t_state  n_state;
    t_dp_cmd w_cmd;
    logic    r_m_valid;

    always_comb begin
        n_state = r_state;
        w_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_s_valid) begin
                    w_cmd.start = 1'b1;
                    n_state     = ST_SCAN;
                end
            end
            ST_SCAN: begin
                w_cmd.scan = 1'b1;
                if (!i_status.op_req || i_status.scan_done) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                w_cmd.exec = 1'b1;
                n_state    = ST_LK1;
            end
            ST_LK1: begin
                w_cmd.lk1 = 1'b1;
                n_state   = ST_LK2;
            end
            ST_LK2: begin
                w_cmd.lk2 = 1'b1;
                n_state   = ST_FIN;
            end
            ST_FIN: begin
                if (!r_m_valid || i_m_ready) begin
                    w_cmd.load_out = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_m_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_cmd.load_out) begin
                r_m_valid <= 1'b1;
            end else if (i_m_ready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    assign o_cmd     = w_cmd;
    assign o_s_ready = (r_state == ST_IDLE);
    assign o_m_valid = r_m_valid;

endmodule

`default_nettype wire

[hw/rtl/pcg_dp.sv]
`timescale 1ns / 1ps
`default_nettype none

module pcg_dp #(
    parameter int unsigned RING_SIZE   = 8,
    parameter int unsigned ID_CAPACITY = 64
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic [pcg_pkg::IN_DATA_W-1:0]     i_s_tdata,
    input  logic [pcg_pkg::OP_W-1:0]          i_s_tuser,
    input  logic                              i_cfg_we,
    input  logic [pcg_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [pcg_pkg::DATA_W-1:0]        i_cfg_wdata,
    input  pcg_pkg::t_dp_cmd                  i_cmd,
    output pcg_pkg::t_dp_status               o_status,
    output logic [pcg_pkg::OUT_DATA_W-1:0]    o_m_tdata
);
    import pcg_pkg::*;

    localparam int unsigned RW = (RING_SIZE > 1) ? $clog2(RING_SIZE) : 1;
    localparam int unsigned FW = $clog2(RING_SIZE + 1);

    // configuration
    logic [DATA_W-1:0] r_max_run;
    logic [DATA_W-1:0] r_cooldown;
    logic [DATA_W-1:0] r_host_to;

    // latched input beat
    t_in_beat          w_in;
    t_op               r_op;
    logic [7:0]        r_byte;
    logic [DATA_W-1:0] r_req;
    logic [DATA_W-1:0] r_now;

    // id digest
    logic [DATA_W-1:0] r_hash;
    logic [LEN_W-1:0]  r_len;
    logic [DATA_W-1:0] w_hash_next;

    // digest ring, contents undefined until written
    logic [DATA_W-1:0] r_ring [RING_SIZE];
    logic [DATA_W-1:0] r_rd;
    logic [RW-1:0]     r_wptr;
    logic [FW-1:0]     r_fill;
    logic [FW-1:0]     r_scan_idx;
    logic              r_cmp_vld;
    logic              r_dup;
    logic              w_ring_we;

    // run state
    logic              r_running;
    logic              r_ever;
    logic              r_run_clamped;
    logic [DATA_W-1:0] r_start;
    logic [DATA_W-1:0] r_grant;
    logic [DATA_W-1:0] r_last_host;
    logic [DATA_W-1:0] r_last_stop;

    // step results
    logic              r_res_acc;
    t_reject           r_res_reason;
    logic [DATA_W-1:0] r_res_granted;
    logic              r_res_clamp;
    logic              r_res_stopped;
    t_cause            r_res_cause;
    logic [DATA_W-1:0] r_res_rt;

    // lockout pipeline
    logic [DATA_W-1:0] r_t1;
    logic [DATA_W-1:0] r_rem;
    logic [DATA_W-1:0] w_ref;
    logic [DATA_W:0]   w_diff;
    logic [DATA_W:0]   w_sum;
    logic [DATA_W-1:0] w_lockout;
    t_out_beat         r_out;

    // decision terms
    logic              w_op_req;
    logic              w_op_tick;
    logic              w_bad;
    logic [DATA_W-1:0] w_since_stop;
    logic              w_cool;
    logic              w_clamp;
    logic [DATA_W-1:0] w_granted;
    logic [DATA_W-1:0] w_el;
    logic              w_deadline;
    logic              w_silent;
    t_reject           w_reason;
    t_cause            w_cause;
    logic              w_acc;

    assign w_in      = i_s_tdata;
    assign w_op_req  = (r_op == OP_REQUEST);
    assign w_op_tick = (r_op == OP_TICK);

    assign w_hash_next = (r_hash ^ {24'd0, r_byte}) * FNV_PRIME;

    assign w_bad = (r_len == '0) || (r_len >= LEN_W'(ID_CAPACITY)) || (r_req == '0);
    assign w_since_stop = r_now - r_last_stop;
    assign w_cool       = r_ever && (w_since_stop < r_cooldown);
    assign w_clamp      = (r_req > r_max_run);
    assign w_granted    = w_clamp ? r_max_run : r_req;
    assign w_el         = r_now - r_start;
    assign w_deadline   = (w_el >= r_grant);
    assign w_silent     = ((r_now - r_last_host) >= r_host_to);

    always_comb begin
        if (w_bad) begin
            w_reason = REJ_BAD;
        end else if (r_dup) begin
            w_reason = REJ_DUP;
        end else if (r_running) begin
            w_reason = REJ_BUSY;
        end else if (w_cool) begin
            w_reason = REJ_COOLDOWN;
        end else begin
            w_reason = REJ_NONE;
        end
    end

    always_comb begin
        if (!r_running) begin
            w_cause = CAUSE_NONE;
        end else if (w_deadline) begin
            w_cause = r_run_clamped ? CAUSE_MAX_RUN : CAUSE_VOLUME;
        end else if (w_silent) begin
            w_cause = CAUSE_WATCHDOG;
        end else begin
            w_cause = CAUSE_NONE;
        end
    end

    assign w_acc     = w_op_req && (w_reason == REJ_NONE);
    assign w_ring_we = i_cmd.exec && w_acc;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_run  <= MAX_RUN_RST;
            r_cooldown <= COOLDOWN_RST;
            r_host_to  <= HOST_TO_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MAX_RUN:      r_max_run  <= i_cfg_wdata;
                CFG_COOLDOWN:     r_cooldown <= i_cfg_wdata;
                CFG_HOST_TIMEOUT: r_host_to  <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // ring memory
    always_ff @(posedge i_clk) begin
        if (w_ring_we) begin
            r_ring[r_wptr] <= r_hash;
        end
        if (i_cmd.scan) begin
            r_rd <= r_ring[r_scan_idx[RW-1:0]];
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash     <= FNV_BASIS;
            r_len      <= '0;
            r_wptr     <= '0;
            r_fill     <= '0;
            r_running  <= 1'b0;
            r_ever     <= 1'b0;
            r_scan_idx <= '0;
            r_cmp_vld  <= 1'b0;
            r_dup      <= 1'b0;
        end else begin
            if (i_cmd.start) begin
                r_scan_idx <= '0;
                r_cmp_vld  <= 1'b0;
                r_dup      <= 1'b0;
            end
            if (i_cmd.scan) begin
                if (r_scan_idx < r_fill) begin
                    r_scan_idx <= r_scan_idx + FW'(1);
                    r_cmp_vld  <= 1'b1;
                end else begin
                    r_cmp_vld <= 1'b0;
                end
                if (r_cmp_vld && (r_rd == r_hash)) begin
                    r_dup <= 1'b1;
                end
            end
            if (i_cmd.exec) begin
                case (r_op)
                    OP_ID_BYTE: begin
                        if (r_byte != 8'd0) begin
                            r_hash <= w_hash_next;
                            if (r_len != LEN_MAX) begin
                                r_len <= r_len + LEN_W'(1);
                            end
                        end
                    end
                    OP_REQUEST: begin
                        r_hash <= FNV_BASIS;
                        r_len  <= '0;
                        if (w_acc) begin
                            r_running <= 1'b1;
                            r_wptr    <= (r_wptr == RW'(RING_SIZE - 1)) ? '0
                                                                         : r_wptr + RW'(1);
                            if (r_fill < FW'(RING_SIZE)) begin
                                r_fill <= r_fill + FW'(1);
                            end
                        end
                    end
                    OP_TICK: begin
                        if (w_cause != CAUSE_NONE) begin
                            r_running <= 1'b0;
                            r_ever    <= 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_op   <= t_op'(i_s_tuser);
            r_byte <= w_in.id_byte;
            r_req  <= w_in.requested_ms;
            r_now  <= w_in.now_ms;
        end
        if (i_cmd.exec) begin
            r_res_acc     <= w_acc;
            r_res_reason  <= w_op_req ? w_reason : REJ_NONE;
            r_res_granted <= w_acc ? w_granted : '0;
            r_res_clamp   <= w_acc && w_clamp;
            r_res_stopped <= w_op_tick && (w_cause != CAUSE_NONE);
            r_res_cause   <= w_op_tick ? w_cause : CAUSE_NONE;
            r_res_rt      <= (w_op_tick && (w_cause != CAUSE_NONE)) ? w_el : '0;
            if (w_acc) begin
                r_start       <= r_now;
                r_grant       <= w_granted;
                r_run_clamped <= w_clamp;
                r_last_host   <= r_now;
            end
            if (r_op == OP_HOST) begin
                r_last_host <= r_now;
            end
            if (w_op_tick && (w_cause != CAUSE_NONE)) begin
                r_last_stop <= r_now;
            end
        end
        if (i_cmd.lk1) begin
            r_t1 <= r_now - (r_running ? r_start : r_last_stop);
        end
        if (i_cmd.lk2) begin
            r_rem <= w_diff[DATA_W] ? '0 : w_diff[DATA_W-1:0];
        end
        if (i_cmd.load_out) begin
            r_out.pad             <= '0;
            r_out.pump_on         <= r_running;
            r_out.lockout_left_ms <= w_lockout;
            r_out.run_time_ms     <= r_res_rt;
            r_out.stop_cause      <= r_res_cause;
            r_out.stopped         <= r_res_stopped;
            r_out.was_clamped     <= r_res_clamp;
            r_out.granted_ms      <= r_res_granted;
            r_out.reject_reason   <= r_res_reason;
            r_out.accepted        <= r_res_acc;
        end
    end

    // remaining time: run deadline while running, else cooldown window
    assign w_ref  = r_running ? r_grant : r_cooldown;
    assign w_diff = {1'b0, w_ref} - {1'b0, r_t1};
    assign w_sum  = {1'b0, r_rem} + {1'b0, r_cooldown};

    always_comb begin
        if (r_running) begin
            w_lockout = w_sum[DATA_W] ? '1 : w_sum[DATA_W-1:0];
        end else if (r_ever) begin
            w_lockout = r_rem;
        end else begin
            w_lockout = '0;
        end
    end

    assign o_status.op_req    = w_op_req;
    assign o_status.scan_done = (r_scan_idx >= r_fill) && !r_cmp_vld;
    assign o_m_tdata          = r_out;

endmodule

`default_nettype wire

[hw/rtl/pump_command_guard.sv]
// sequence: a result beat follows its input beat through the ring search, execute, lockout and
//   result-load steps; a pump request searches the filled entries of the digest ring
//   (one entry per cycle, one read port), none while the ring is still empty
// flow: the input side is closed while an item is in flight and opens once its result is loaded;
//   the result waits in an output register
// reset: synchronous, active low; clears the run flags, digest and ring fill, and
//   loads the register defaults; ring contents stay undefined until written
`timescale 1ns / 1ps
`default_nettype none

module pump_command_guard #(
    parameter int unsigned RING_SIZE   = 8,
    parameter int unsigned ID_CAPACITY = 64
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // input beat
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // id_byte[7:0], requested_ms[39:8], now_ms[71:40]
    input  logic [pcg_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // op[1:0]
    input  logic [pcg_pkg::OP_W-1:0]          s_axis_tuser,
    // result beat
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // accepted[0], reject_reason[3:1], granted_ms[35:4], was_clamped[36],
    // stopped[37], stop_cause[39:38], run_time_ms[71:40], lockout_left_ms[103:72],
    // pump_on[104], zero fill[111:105]
    output logic [pcg_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    // register writes
    input  logic                              i_cfg_we,
    input  logic [pcg_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [pcg_pkg::DATA_W-1:0]        i_cfg_wdata
);
    import pcg_pkg::*;

    t_dp_cmd    w_cmd;
    t_dp_status w_status;
    t_out_beat  w_out_beat;

    // sequencer: accept, ring search, execute, two lockout steps, result load
    pcg_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_axis_tvalid),
        .i_m_ready (m_axis_tready),
        .i_status  (w_status),
        .o_cmd     (w_cmd),
        .o_s_ready (s_axis_tready),
        .o_m_valid (m_axis_tvalid)
    );

    // digest, ring, run timers and result register
    pcg_dp #(
        .RING_SIZE   (RING_SIZE),
        .ID_CAPACITY (ID_CAPACITY)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tdata   (s_axis_tdata),
        .i_s_tuser   (s_axis_tuser),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .o_m_tdata   (m_axis_tdata)
    );

    assign w_out_beat = m_axis_tdata;

    // one item in flight: the input side closes right after a beat is taken
    a_single_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input taken while an item is in flight");

    // a new result beat is loaded only as the sequencer returns to idle
    a_result_reopens: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> s_axis_tready)
        else $error("result loaded without returning to idle");

    // a granted run leaves the pump on with no reject code
    a_grant_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && w_out_beat.accepted) |->
        (w_out_beat.pump_on && (w_out_beat.reject_reason == REJ_NONE)))
        else $error("granted run without pump on");

    // a stop always names its cause and leaves the pump off
    a_stop_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && w_out_beat.stopped) |->
        (!w_out_beat.pump_on && (w_out_beat.stop_cause != CAUSE_NONE)))
        else $error("stop without cause or pump still on");

endmodule

`default_nettype wire
